// ===== rtl/ida_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ida_pkg
// Shared widths, character codes and controller/datapath handshake structs
// for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package ida_pkg;

  localparam int ValueW      = 32;
  localparam int CharW       = 7;
  localparam int NumDigits   = 10;
  localparam int DigitW      = 4;
  localparam int BcdW        = NumDigits * DigitW;
  localparam int DigitIdxW   = 4;
  localparam int BitsPerStep = 4;
  localparam int NumSteps    = ValueW / BitsPerStep;
  localparam int StepCntW    = 3;

  localparam logic [CharW-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CharW-1:0] CHAR_MINUS = 7'h2d;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic find;
    logic push_sign;
    logic push_digit;
  } ida_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic idx_zero;
    logic can_push;
  } ida_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ida_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ida_in_if
// Input channel: one signed integer per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ida_in_if import ida_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/ida_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ida_out_if
// Result channel: one ASCII character per item plus an end-of-text flag.
// ----------------------------------------------------------------------------
interface ida_out_if import ida_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ida_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ida_dpath
// Datapath: magnitude register, double-dabble BCD converter working four
// bits per cycle, leading digit search and the output character register.
// ----------------------------------------------------------------------------
module ida_dpath import ida_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [ValueW-1:0] value,
  input  wire ida_cmd_t                 cmd,
  output ida_stat_t                     stat,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [CharW-1:0]              character,
  output logic                          last
);

  // One double-dabble bit: add three to every digit of five or more, then
  // shift the next magnitude bit in.
  function automatic logic [BcdW-1:0] dd_shift(input logic [BcdW-1:0] bcd,
                                               input logic bit_in);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (adj[d*DigitW +: DigitW] >= DigitW'(5)) begin
        adj[d*DigitW +: DigitW] = adj[d*DigitW +: DigitW] + DigitW'(3);
      end
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

  logic [ValueW-1:0]    mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [BcdW-1:0]      bcd_r, bcd_nxt;
  logic [StepCntW-1:0]  step_r, step_nxt;
  logic [DigitIdxW-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CharW-1:0]     char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic [BcdW-1:0]      bcd_conv;
  logic [DigitIdxW-1:0] msd;
  logic [DigitW-1:0]    cur_digit;
  logic [ValueW-1:0]    raw;

  assign raw = $unsigned(value);

  always_comb begin
    logic [BcdW-1:0] tmp;
    tmp = bcd_r;
    for (int i = 0; i < BitsPerStep; i++) begin
      tmp = dd_shift(tmp, mag_r[ValueW-1-i]);
    end
    bcd_conv = tmp;
  end

  // Highest nonzero digit; zero falls back to the units digit.
  always_comb begin
    msd = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_r[i*DigitW +: DigitW] != '0) begin
        msd = DigitIdxW'(i);
      end
    end
  end

  assign cur_digit = bcd_r[{idx_r, 2'b00} +: DigitW];

  assign stat.conv_done = (step_r == StepCntW'(NumSteps - 1));
  assign stat.neg       = neg_r;
  assign stat.idx_zero  = (idx_r == '0);
  assign stat.can_push  = !out_valid_r || out_ready;

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (cmd.load) begin
      neg_nxt  = raw[ValueW-1];
      mag_nxt  = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;
      bcd_nxt  = '0;
      step_nxt = '0;
    end
    if (cmd.conv) begin
      bcd_nxt  = bcd_conv;
      mag_nxt  = {mag_r[ValueW-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
      step_nxt = step_r + StepCntW'(1);
    end
    if (cmd.find) begin
      idx_nxt = msd;
    end
    if (cmd.push_sign) begin
      char_nxt      = CHAR_MINUS;
      last_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.push_digit) begin
      char_nxt      = CHAR_ZERO + {{(CharW-DigitW){1'b0}}, cur_digit};
      last_nxt      = (idx_r == '0);
      idx_nxt       = idx_r - DigitIdxW'(1);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign character = char_r;
  assign last      = last_r;

endmodule
`default_nettype wire

// ===== rtl/ida_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ida_ctrl
// Controller: sequences load, conversion, leading digit search and the
// emission of the sign and digit characters.
// ----------------------------------------------------------------------------
module ida_ctrl import ida_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ida_stat_t stat,
  output ida_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_FIND  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } ida_state_t;

  ida_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (stat.conv_done) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = stat.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (stat.can_push) begin
          cmd.push_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (stat.can_push) begin
          cmd.push_digit = 1'b1;
          if (stat.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/int_to_decimal_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Each input item is a signed 32-bit integer; the block returns its decimal
// text one ASCII character per result item, most significant first, with a
// leading '-' for negative values, no leading zeros, and last set on the
// final digit. The most negative value prints in full as -2147483648. A
// number, of 1 to 11 characters, passes through these steps in order:
// acceptance, the double-dabble converter taking four magnitude bits per
// cycle, the search for the leading digit, then one character per cycle
// through the output register while the output is not stalled. A new
// number is taken once the last character sits in the output register,
// even if it has not yet been read.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii import ida_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ida_in_if.sink    in_ch,
  ida_out_if.source out_ch
);

  ida_cmd_t  cmd;
  ida_stat_t stat;

  ida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ida_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .value     (in_ch.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .character (out_ch.character),
    .last      (out_ch.last)
  );

  // The converter is busy after taking a number.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted again right after an item");

  // The text always ends on a digit.
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |->
      (out_ch.character >= CHAR_ZERO) && (out_ch.character <= CHAR_NINE))
    else $error("final character is not a digit");

  // Only a digit or the minus sign is ever emitted.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (out_ch.character == CHAR_MINUS) ||
      ((out_ch.character >= CHAR_ZERO) && (out_ch.character <= CHAR_NINE)))
    else $error("illegal character emitted");

endmodule
`default_nettype wire
